[hw/rtl/assert_macros.svh]
// Assertion macros shared by the TLB RTL; clocked on clk, disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset
`define TLBFL_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("TLB assertion failed");
// Condition must never be true outside reset
`define TLBFL_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("TLB forbidden condition seen");
`else
`define TLBFL_ASSERT(lbl, prop)
`define TLBFL_NEVER(lbl, cond)
`endif
`endif

[hw/rtl/tlbfl_pkg.sv]
// Shared types and constants of the TLB with FIFO/LRU replacement.
`default_nettype none
package tlbfl_pkg;

    // Field widths
    localparam int PROC_W      = 16;
    localparam int PAGE_W      = 20;
    localparam int FRAME_W     = 20;
    localparam int SLOT_W      = 5;
    localparam int CAP_W       = 6;
    localparam int CFG_DATA_W  = 6;
    localparam int CFG_IDX_W   = 1;
    // Widest slot index for the supported table depths (up to 256)
    localparam int IDX_MAX_W   = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POLICY_LRU = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = 1'b1;

    // Configuration reset values
    localparam logic       POLICY_RESET   = 1'b0;
    localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

    // Request kind after decode
    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_INSERT = 1'b1
    } op_t;

    // One decoded request
    typedef struct packed {
        op_t                op;
        logic [PROC_W-1:0]  proc_id;
        logic [PAGE_W-1:0]  page_num;
        logic [FRAME_W-1:0] frame_in;
    } req_t;

    // Configuration seen by the execution side
    typedef struct packed {
        logic             policy_lru;
        logic [CAP_W-1:0] capacity;
    } cfg_t;

endpackage
`default_nettype wire

[hw/rtl/tlbfl_front.sv]
// Front end: accepts input items, decodes the command and stages them for the queue.
`default_nettype none
module tlbfl_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        cmd,
    input  wire logic [tlbfl_pkg::PROC_W-1:0]  proc_id,
    input  wire logic [tlbfl_pkg::PAGE_W-1:0]  page_num,
    input  wire logic [tlbfl_pkg::FRAME_W-1:0] frame_in,
    output logic                             push_valid,
    input  wire logic                        push_ready,
    output tlbfl_pkg::req_t                  push_req
);

    logic            stage_valid_reg;
    logic            stage_valid_next;
    tlbfl_pkg::req_t stage_req_reg;
    tlbfl_pkg::req_t decoded;

    // Decode the raw command into a request kind
    always_comb
    begin
        decoded.op       = cmd ? tlbfl_pkg::OP_INSERT : tlbfl_pkg::OP_LOOKUP;
        decoded.proc_id  = proc_id;
        decoded.page_num = page_num;
        decoded.frame_in = frame_in;
    end

    // Stage register: refills in the same cycle it drains
    assign in_ready   = !stage_valid_reg || push_ready;
    assign push_valid = stage_valid_reg;
    assign push_req   = stage_req_reg;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (in_ready)
        begin
            stage_valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stage_req_reg <= decoded;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/tlbfl_queue.sv]
// Two-entry request queue between the front end and the table engine.
`default_nettype none
`include "assert_macros.svh"
module tlbfl_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push_valid,
    output logic                 push_ready,
    input  wire tlbfl_pkg::req_t push_req,
    output logic                 pop_valid,
    input  wire logic            pop_ready,
    output tlbfl_pkg::req_t      pop_req
);

    localparam logic [1:0] QDEPTH = 2'd2;

    tlbfl_pkg::req_t slot_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (count_reg != QDEPTH);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_req    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_req;
        end
    end

    `TLBFL_NEVER(a_q_overfill, count_reg > QDEPTH)
    `TLBFL_ASSERT(a_q_ptr_gap, (count_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg))

endmodule
`default_nettype wire

[hw/rtl/tlbfl_back.sv]
// Table engine: parallel tag match, age-matrix victim choice, entry update, result register.
`default_nettype none
`include "assert_macros.svh"
module tlbfl_back #(
    parameter int ENTRIES = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire tlbfl_pkg::cfg_t               cfg,
    input  wire logic                          req_valid,
    output logic                               req_ready,
    input  wire tlbfl_pkg::req_t               req,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               hit,
    output logic [tlbfl_pkg::FRAME_W-1:0]      frame_out,
    output logic                               replaced,
    output logic [tlbfl_pkg::SLOT_W-1:0]       slot_index
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > tlbfl_pkg::CAP_W) ? CNT_W : tlbfl_pkg::CAP_W;

    typedef enum logic {
        S_EVAL,
        S_WRITE
    } state_t;

    // Entry storage; older_reg[i][j] set means entry i was touched before entry j
    logic [tlbfl_pkg::PROC_W-1:0]  proc_reg  [ENTRIES];
    logic [tlbfl_pkg::PAGE_W-1:0]  page_reg  [ENTRIES];
    logic [tlbfl_pkg::FRAME_W-1:0] frame_reg [ENTRIES];
    logic [ENTRIES-1:0]            older_reg [ENTRIES];

    state_t                         state_reg;
    logic [CNT_W-1:0]               filled_reg;

    // Item under execution and its evaluation results
    tlbfl_pkg::op_t                 cur_op_reg;
    logic [tlbfl_pkg::PROC_W-1:0]   cur_proc_reg;
    logic [tlbfl_pkg::PAGE_W-1:0]   cur_page_reg;
    logic [tlbfl_pkg::FRAME_W-1:0]  cur_frame_reg;
    logic                           hit_reg;
    logic [IDX_W-1:0]               hit_idx_reg;
    logic [tlbfl_pkg::FRAME_W-1:0]  hit_frame_reg;
    logic                           full_reg;
    logic [IDX_W-1:0]               victim_reg;

    // Result register
    logic                           out_valid_reg;
    logic                           out_hit_reg;
    logic [tlbfl_pkg::FRAME_W-1:0]  out_frame_reg;
    logic                           out_replaced_reg;
    logic [tlbfl_pkg::SLOT_W-1:0]   out_slot_reg;

    logic [ENTRIES-1:0]             filled_vec;
    logic [ENTRIES-1:0]             match_vec;
    logic [ENTRIES-1:0]             cand_vec;
    logic                           match_any;
    logic [IDX_W-1:0]               match_idx;
    logic [IDX_W-1:0]               victim_idx;
    logic [CMP_W-1:0]               cap_ext;
    logic [CMP_W-1:0]               cap_eff;
    logic                           table_full;
    logic                           out_free;
    logic                           write_en;
    logic                           is_insert;
    logic [IDX_W-1:0]               slot_sel;
    logic                           touch_en;
    logic [IDX_W-1:0]               touch_idx;
    logic [tlbfl_pkg::IDX_MAX_W:0]  slot_wide;
    logic [tlbfl_pkg::IDX_MAX_W:0]  hit_wide;

    // Tag compare across all filled entries
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            filled_vec[i] = (CNT_W'(i) < filled_reg);
            match_vec[i]  = filled_vec[i] && (proc_reg[i] == req.proc_id)
                            && (page_reg[i] == req.page_num);
        end
    end

    // Oldest filled entry: older than every other filled entry
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            cand_vec[i] = filled_vec[i];
            for (int j = 0; j < ENTRIES; j++)
            begin
                if ((j != i) && filled_vec[j] && !older_reg[i][j])
                begin
                    cand_vec[i] = 1'b0;
                end
            end
        end
    end

    // Lowest-index encoders
    always_comb
    begin
        match_any  = |match_vec;
        match_idx  = '0;
        victim_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (match_vec[i])
            begin
                match_idx = IDX_W'(i);
            end
            if (cand_vec[i])
            begin
                victim_idx = IDX_W'(i);
            end
        end
    end

    // Capacity clamped to 1..ENTRIES
    always_comb
    begin
        cap_ext = CMP_W'(cfg.capacity);
        priority if (cap_ext == '0)
        begin
            cap_eff = CMP_W'(1);
        end
        else if (cap_ext > CMP_W'(ENTRIES))
        begin
            cap_eff = CMP_W'(ENTRIES);
        end
        else
        begin
            cap_eff = cap_ext;
        end
        table_full = (CMP_W'(filled_reg) >= cap_eff);
    end

    // Write phase controls
    assign req_ready = (state_reg == S_EVAL);
    assign out_free  = !out_valid_reg || out_ready;
    assign write_en  = (state_reg == S_WRITE) && out_free;
    assign is_insert = (cur_op_reg == tlbfl_pkg::OP_INSERT);
    assign slot_sel  = full_reg ? victim_reg : filled_reg[IDX_W-1:0];
    assign touch_en  = write_en && (is_insert || (hit_reg && cfg.policy_lru));
    assign touch_idx = is_insert ? slot_sel : hit_idx_reg;
    assign slot_wide = (tlbfl_pkg::IDX_MAX_W + 1)'(slot_sel);
    assign hit_wide  = (tlbfl_pkg::IDX_MAX_W + 1)'(hit_idx_reg);

    // Sequencer, evaluation registers and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_EVAL;
            filled_reg       <= '0;
            cur_op_reg       <= tlbfl_pkg::OP_LOOKUP;
            cur_proc_reg     <= '0;
            cur_page_reg     <= '0;
            cur_frame_reg    <= '0;
            hit_reg          <= 1'b0;
            hit_idx_reg      <= '0;
            hit_frame_reg    <= '0;
            full_reg         <= 1'b0;
            victim_reg       <= '0;
            out_valid_reg    <= 1'b0;
            out_hit_reg      <= 1'b0;
            out_frame_reg    <= '0;
            out_replaced_reg <= 1'b0;
            out_slot_reg     <= '0;
        end
        else
        begin
            // Result valid: set on a write, cleared when taken
            if (write_en)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_EVAL:
                begin
                    if (req_valid)
                    begin
                        cur_op_reg    <= req.op;
                        cur_proc_reg  <= req.proc_id;
                        cur_page_reg  <= req.page_num;
                        cur_frame_reg <= req.frame_in;
                        hit_reg       <= match_any;
                        hit_idx_reg   <= match_idx;
                        hit_frame_reg <= frame_reg[match_idx];
                        full_reg      <= table_full;
                        victim_reg    <= victim_idx;
                        state_reg     <= S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    if (out_free)
                    begin
                        if (is_insert)
                        begin
                            out_hit_reg      <= 1'b0;
                            out_frame_reg    <= '0;
                            out_replaced_reg <= full_reg;
                            out_slot_reg     <= slot_wide[tlbfl_pkg::SLOT_W-1:0];
                            if (!full_reg)
                            begin
                                filled_reg <= filled_reg + CNT_W'(1);
                            end
                        end
                        else
                        begin
                            out_hit_reg      <= hit_reg;
                            out_frame_reg    <= hit_reg ? hit_frame_reg : '0;
                            out_replaced_reg <= 1'b0;
                            out_slot_reg     <= hit_reg ? hit_wide[tlbfl_pkg::SLOT_W-1:0] : '0;
                        end
                        state_reg <= S_EVAL;
                    end
                end
            endcase
        end
    end

    // Entry and age updates; a touched entry becomes younger than all others
    always_ff @(posedge clk)
    begin
        if (write_en && is_insert)
        begin
            proc_reg[slot_sel]  <= cur_proc_reg;
            page_reg[slot_sel]  <= cur_page_reg;
            frame_reg[slot_sel] <= cur_frame_reg;
        end
        if (touch_en)
        begin
            for (int j = 0; j < ENTRIES; j++)
            begin
                if (IDX_W'(j) != touch_idx)
                begin
                    older_reg[touch_idx][j] <= 1'b0;
                    older_reg[j][touch_idx] <= 1'b1;
                end
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign hit        = out_hit_reg;
    assign frame_out  = out_frame_reg;
    assign replaced   = out_replaced_reg;
    assign slot_index = out_slot_reg;

    `TLBFL_NEVER(a_fill_bound, filled_reg > CNT_W'(ENTRIES))
    `TLBFL_ASSERT(a_fill_monotonic, 1'b1 |=> (filled_reg >= $past(filled_reg)))
    `TLBFL_ASSERT(a_write_gives_result, write_en |=> out_valid_reg)
    `TLBFL_NEVER(a_hit_and_replace, out_valid_reg && out_hit_reg && out_replaced_reg)
    `TLBFL_ASSERT(a_victim_exists, (state_reg == S_EVAL && req_valid && table_full)
                  |-> ($countones(cand_vec) == 1))

endmodule
`default_nettype wire

[hw/rtl/tlb_fifo_lru_unit.sv]
// Fully associative TLB with FIFO or LRU replacement: top level and configuration registers.
// Path of an item: input stage, queue, engine evaluation registers, result register.
// The engine accepts a new item only after the write phase of the previous one has finished.
// Replacement order is kept in an age matrix updated on each insert (and on LRU hits).
// Reset: table empty, policy FIFO, capacity 32; entry contents are not cleared.
`default_nettype none
module tlb_fifo_lru_unit #(
    parameter int ENTRIES = 32
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [tlbfl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tlbfl_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            cmd,
    input  wire logic [tlbfl_pkg::PROC_W-1:0]     proc_id,
    input  wire logic [tlbfl_pkg::PAGE_W-1:0]     page_num,
    input  wire logic [tlbfl_pkg::FRAME_W-1:0]    frame_in,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 hit,
    output logic [tlbfl_pkg::FRAME_W-1:0]         frame_out,
    output logic                                 replaced,
    output logic [tlbfl_pkg::SLOT_W-1:0]          slot_index
);

    logic                          policy_reg;
    logic [tlbfl_pkg::CAP_W-1:0]   capacity_reg;
    tlbfl_pkg::cfg_t               cfg;
    logic                          push_valid;
    logic                          push_ready;
    tlbfl_pkg::req_t               push_req;
    logic                          pop_valid;
    logic                          pop_ready;
    tlbfl_pkg::req_t               pop_req;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg   <= tlbfl_pkg::POLICY_RESET;
            capacity_reg <= tlbfl_pkg::CAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                tlbfl_pkg::REG_POLICY_LRU:
                begin
                    policy_reg <= cfg_wdata[0];
                end
                tlbfl_pkg::REG_CAPACITY:
                begin
                    capacity_reg <= cfg_wdata[tlbfl_pkg::CAP_W-1:0];
                end
            endcase
        end
    end

    always_comb
    begin
        cfg.policy_lru = policy_reg;
        cfg.capacity   = capacity_reg;
    end

    tlbfl_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .proc_id    (proc_id),
        .page_num   (page_num),
        .frame_in   (frame_in),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_req   (push_req)
    );

    tlbfl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_req   (push_req),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_req    (pop_req)
    );

    tlbfl_back #(
        .ENTRIES (ENTRIES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .req_valid  (pop_valid),
        .req_ready  (pop_ready),
        .req        (pop_req),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hit        (hit),
        .frame_out  (frame_out),
        .replaced   (replaced),
        .slot_index (slot_index)
    );

endmodule
`default_nettype wire

[test/tb_tlb_fifo_lru_unit.sv]
// Testbench for the FIFO/LRU TLB: directed and random traffic checked against a scoreboard.
`timescale 1ns / 1ps

// One expected response of the TLB
typedef struct packed {
    bit        hit;
    bit [19:0] frame;
    bit        replaced;
    bit [4:0]  slot;
} tlb_resp_t;

// Table mirror: tracks entries, stamps and config, queues the expected responses
class tlb_scoreboard;
    localparam int DEPTH = 32;

    bit        policy_lru;
    bit [5:0]  capacity;
    int        filled;
    bit [15:0] ent_proc[DEPTH];
    bit [19:0] ent_page[DEPTH];
    bit [19:0] ent_frame[DEPTH];
    bit [47:0] ent_stamp[DEPTH];
    bit [47:0] access_count;
    tlb_resp_t resp_q[$];
    int        errors;

    function new();
        policy_lru   = 1'b0;
        capacity     = 6'd32;
        filled       = 0;
        access_count = '0;
        errors       = 0;
    endfunction

    function int pending();
        return resp_q.size();
    endfunction

    // Key of some filled entry, for lookups that should hit
    function void any_entry(output bit [15:0] p, output bit [19:0] pg);
        int unsigned i;
        i  = $urandom_range(filled - 1);
        p  = ent_proc[i];
        pg = ent_page[i];
    endfunction

    // Accepted request: update the mirror and queue its response
    function void note_request(tlbfl_pkg::op_t op, bit [15:0] p, bit [19:0] pg, bit [19:0] fr);
        tlb_resp_t r;
        int        eff_cap;
        int        slot;
        r = '0;
        if (op == tlbfl_pkg::OP_LOOKUP) begin
            // lowest-index match wins
            for (int i = 0; i < filled; i++) begin
                if (ent_proc[i] == p && ent_page[i] == pg) begin
                    if (policy_lru)
                        ent_stamp[i] = access_count;
                    r.hit   = 1'b1;
                    r.frame = ent_frame[i];
                    r.slot  = i[4:0];
                    break;
                end
            end
        end
        else begin
            eff_cap = capacity;
            if (eff_cap < 1)
                eff_cap = 1;
            if (eff_cap > DEPTH)
                eff_cap = DEPTH;
            if (filled < eff_cap) begin
                slot   = filled;
                filled = filled + 1;
            end
            else begin
                // oldest stamp among filled entries, lowest index on ties
                slot = 0;
                for (int i = 1; i < filled; i++)
                    if (ent_stamp[i] < ent_stamp[slot])
                        slot = i;
                r.replaced = 1'b1;
            end
            ent_proc[slot]  = p;
            ent_page[slot]  = pg;
            ent_frame[slot] = fr;
            ent_stamp[slot] = access_count;
            r.slot          = slot[4:0];
        end
        access_count = access_count + 48'd1;
        resp_q.push_back(r);
    endfunction

    // Accepted response: compare with the oldest expectation
    function void check_response(bit h, bit [19:0] fr, bit rep, bit [4:0] sl);
        tlb_resp_t e;
        if (resp_q.size() == 0) begin
            $error("unexpected response: hit=%0d frame_out=%h replaced=%0d slot_index=%0d",
                   h, fr, rep, sl);
            errors++;
            return;
        end
        e = resp_q.pop_front();
        if (h !== e.hit) begin
            $error("hit: expected %0d, got %0d", e.hit, h);
            errors++;
        end
        if (fr !== e.frame) begin
            $error("frame_out: expected %h, got %h", e.frame, fr);
            errors++;
        end
        if (rep !== e.replaced) begin
            $error("replaced: expected %0d, got %0d", e.replaced, rep);
            errors++;
        end
        if (sl !== e.slot) begin
            $error("slot_index: expected %0d, got %0d", e.slot, sl);
            errors++;
        end
    endfunction
endclass

module tb_tlb_fifo_lru_unit;

    localparam int TLB_DEPTH   = 32;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASES      = 9;
    localparam int PHASE_ITEMS = 105;

    logic                             clk        = 1'b0;
    logic                             rst_n      = 1'b0;
    logic                             cfg_wr_en  = 1'b0;
    logic [tlbfl_pkg::CFG_IDX_W-1:0]  cfg_index  = tlbfl_pkg::REG_POLICY_LRU;
    logic [tlbfl_pkg::CFG_DATA_W-1:0] cfg_wdata  = '0;
    logic                             in_valid   = 1'b0;
    logic                             in_ready;
    logic                             cmd        = 1'b0;
    logic [tlbfl_pkg::PROC_W-1:0]     proc_id    = '0;
    logic [tlbfl_pkg::PAGE_W-1:0]     page_num   = '0;
    logic [tlbfl_pkg::FRAME_W-1:0]    frame_in   = '0;
    logic                             out_valid;
    logic                             out_ready  = 1'b0;
    logic                             hit;
    logic [tlbfl_pkg::FRAME_W-1:0]    frame_out;
    logic                             replaced;
    logic [tlbfl_pkg::SLOT_W-1:0]     slot_index;

    tlb_scoreboard sb = new();

    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic holding = 1'b0;
    int   quiet_cycles = 0;
    event start_hold;

    tlb_fifo_lru_unit #(.ENTRIES(TLB_DEPTH)) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .proc_id    (proc_id),
        .page_num   (page_num),
        .frame_in   (frame_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hit        (hit),
        .frame_out  (frame_out),
        .replaced   (replaced),
        .slot_index (slot_index)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Monitor both channels at the clock edge
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready)
                sb.note_request(tlbfl_pkg::op_t'(cmd), proc_id, page_num, frame_in);
            if (out_valid && out_ready)
                sb.check_response(hit, frame_out, replaced, slot_index);
        end
    end

    // Result side backpressure
    always @(posedge clk) begin
        out_ready <= !holding && ($urandom_range(99) >= recv_stall_pct);
    end

    // Long receiver hold-off so the table pipeline fills and stalls its input
    initial begin
        forever begin
            @(start_hold);
            holding <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            holding <= 1'b0;
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb_tlb_fifo_lru_unit: done, errors");
                $finish;
            end
        end
    end

    // Offer one item, with optional idle cycles ahead of it
    task automatic send_item(tlbfl_pkg::op_t op, bit [15:0] p, bit [19:0] pg, bit [19:0] fr);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= op;
        proc_id  <= p;
        page_num <= pg;
        frame_in <= fr;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Random request biased toward keys already in the table
    task automatic send_random();
        bit [15:0] p;
        bit [19:0] pg;
        bit [19:0] fr;
        int unsigned k;
        k  = $urandom_range(99);
        fr = 20'($urandom());
        p  = 16'($urandom());
        pg = 20'($urandom());
        if ($urandom_range(99) < 55) begin
            if (k < 65 && sb.filled > 0) begin
                sb.any_entry(p, pg);
            end
            else if (k < 80 && sb.filled > 0) begin
                // near miss: one half of the key matches
                if (k < 72)
                    sb.any_entry(p, pg);
                else
                    sb.any_entry(p, pg);
                if (k[0])
                    pg = pg ^ (20'd1 << $urandom_range(19));
                else
                    p = p ^ (16'd1 << $urandom_range(15));
            end
            else if (k < 90) begin
                p  = 16'($urandom_range(3));
                pg = 20'($urandom_range(7));
            end
            send_item(tlbfl_pkg::OP_LOOKUP, p, pg, fr);
        end
        else begin
            if (k < 30 && sb.filled > 0) begin
                sb.any_entry(p, pg);
            end
            else if (k < 50) begin
                p  = 16'($urandom_range(3));
                pg = 20'($urandom_range(7));
            end
            send_item(tlbfl_pkg::OP_INSERT, p, pg, fr);
        end
    endtask

    // Write both registers; only called with the table idle
    task automatic set_config(bit pol, bit [5:0] cap);
        cfg_wr_en <= 1'b1;
        cfg_index <= tlbfl_pkg::REG_POLICY_LRU;
        cfg_wdata <= {5'b0, pol};
        @(posedge clk);
        cfg_index <= tlbfl_pkg::REG_CAPACITY;
        cfg_wdata <= cap;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.policy_lru = pol;
        sb.capacity   = cap;
        @(posedge clk);
    endtask

    // Drop valid and wait out all outstanding responses
    task automatic drain();
        in_valid <= 1'b0;
        // let the monitor note the last accepted item first
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    initial begin
        bit       pol_tab[PHASES];
        bit [5:0] cap_tab[PHASES];

        pol_tab = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
        cap_tab = '{6'd4, 6'd0, 6'd12, 6'd32, 6'd63, 6'd32, 6'd1, 6'd20, 6'd8};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset config (FIFO, full capacity), field extremes, duplicates
        send_item(tlbfl_pkg::OP_LOOKUP, 16'h0000, 20'h00000, 20'h00000);  // empty table
        send_item(tlbfl_pkg::OP_INSERT, 16'h0000, 20'h00000, 20'hFFFFF);
        send_item(tlbfl_pkg::OP_INSERT, 16'hFFFF, 20'hFFFFF, 20'h00000);
        send_item(tlbfl_pkg::OP_LOOKUP, 16'h0000, 20'h00000, 20'h00000);
        send_item(tlbfl_pkg::OP_LOOKUP, 16'hFFFF, 20'hFFFFF, 20'hFFFFF);  // frame_in ignored
        send_item(tlbfl_pkg::OP_LOOKUP, 16'h0000, 20'hFFFFF, 20'h00000);  // page only mismatch
        send_item(tlbfl_pkg::OP_LOOKUP, 16'hFFFF, 20'h00000, 20'h00000);  // proc only mismatch
        send_item(tlbfl_pkg::OP_INSERT, 16'h0000, 20'h00000, 20'h12345);  // duplicate key
        send_item(tlbfl_pkg::OP_LOOKUP, 16'h0000, 20'h00000, 20'h00000);  // lowest index wins
        send_item(tlbfl_pkg::OP_INSERT, 16'h5A5A, 20'hA5A5A, 20'h5A5A5);
        send_item(tlbfl_pkg::OP_INSERT, 16'hA5A5, 20'h5A5A5, 20'hA5A5A);
        send_item(tlbfl_pkg::OP_LOOKUP, 16'h5A5A, 20'hA5A5A, 20'h00000);
        send_item(tlbfl_pkg::OP_LOOKUP, 16'hA5A5, 20'h5A5A5, 20'h00000);
        send_item(tlbfl_pkg::OP_LOOKUP, 16'h5A5A, 20'h5A5A5, 20'h00000);
        drain();

        // Random phases over policy/capacity settings and idle patterns
        for (int ph = 0; ph < PHASES; ph++) begin
            set_config(pol_tab[ph], cap_tab[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            if (ph == 4)
                -> start_hold;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_random();
            drain();
        end

        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_tlb_fifo_lru_unit: done, clean");
        else
            $display("tb_tlb_fifo_lru_unit: done, errors");
        $finish;
    end
endmodule

[tlb_fifo_lru_unit.f]
+incdir+hw/rtl
hw/rtl/tlbfl_pkg.sv
hw/rtl/tlbfl_front.sv
hw/rtl/tlbfl_queue.sv
hw/rtl/tlbfl_back.sv
hw/rtl/tlb_fifo_lru_unit.sv
test/tb_tlb_fifo_lru_unit.sv
